[src/mbps_pkg.sv]
// Shared types and constants for the masked byte pattern search block.
// Register map, result beat layout and the front-to-queue push bundle.
// Depends on nothing.
package mbps_pkg;

   localparam int CSR_DATA_W   = 64;
   localparam int CSR_ADDR_W   = 5;
   localparam int CARE_W       = 16;
   localparam int LEN_W        = 5;
   localparam int PAT_BYTES    = 16;
   localparam int OFFSET_OUT_W = 32;

   // register index, taken from paddr[4:3]
   localparam logic [1:0] REG_PATTERN_LOW  = 2'd0;
   localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
   localparam logic [1:0] REG_CARE_MASK    = 2'd2;
   localparam logic [1:0] REG_PATTERN_LEN  = 2'd3;

   localparam logic [CARE_W-1:0] CARE_RESET = 16'hFFFF;
   localparam logic [LEN_W-1:0]  LEN_RESET  = 5'd1;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] pattern_low_bytes;
      logic [CSR_DATA_W-1:0] pattern_high_bytes;
      logic [CARE_W-1:0]     care_mask;
      logic [LEN_W-1:0]      pattern_length;
   } cfg_type;

   typedef struct packed {
      logic                    found;
      logic [OFFSET_OUT_W-1:0] match_offset;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } push_type;

endpackage

[src/mbps_csr.sv]
// Configuration registers behind the APB-style port.
// Uses mbps_pkg for the register map and the cfg_type bundle.
module mbps_csr import mbps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:3];
   assign wr_en   = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low_bytes  <= '0;
         cfg_ff.pattern_high_bytes <= '0;
         cfg_ff.care_mask          <= CARE_RESET;
         cfg_ff.pattern_length     <= LEN_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_PATTERN_LOW:  cfg_ff.pattern_low_bytes  <= pwdata;
            REG_PATTERN_HIGH: cfg_ff.pattern_high_bytes <= pwdata;
            REG_CARE_MASK:    cfg_ff.care_mask          <= pwdata[CARE_W-1:0];
            REG_PATTERN_LEN:  cfg_ff.pattern_length     <= pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PATTERN_LOW:  prdata = cfg_ff.pattern_low_bytes;
         REG_PATTERN_HIGH: prdata = cfg_ff.pattern_high_bytes;
         REG_CARE_MASK:    prdata = {{(CSR_DATA_W-CARE_W){1'b0}}, cfg_ff.care_mask};
         REG_PATTERN_LEN:  prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, cfg_ff.pattern_length};
         default:          prdata = '0;
      endcase
   end

endmodule

[src/mbps_front.sv]
// Front end: takes byte beats, keeps the window and offset counter, runs the
// masked compare and decides whether a beat yields a result.
// Uses mbps_pkg for cfg_type and push_type.
module mbps_front import mbps_pkg::*; #(
   parameter int MAX_PATTERN = 16,
   parameter int OFFSET_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       queue_full,
   output push_type   push
);

   localparam int WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [7:0]             win_ff [MAX_PATTERN];
   logic [7:0]             win_in [MAX_PATTERN];
   logic [OFFSET_BITS-1:0] count_ff;
   logic [OFFSET_BITS-1:0] count_in;
   logic                   reported_ff;

   logic [2*CSR_DATA_W-1:0]         pattern;
   logic [LEN_W-1:0]                len_used;
   logic [LEN_W-1:0]                len_m1;
   logic [LEN_W:0]                  pick;
   logic                            match;
   logic                            hit;
   logic                            fire;
   logic [OFFSET_BITS-1:0]          diff;
   logic [OFFSET_BITS+OFFSET_OUT_W-1:0] diff_ext;

   assign req_ready = ~queue_full;
   assign fire      = req_valid & req_ready;
   assign pattern   = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};

   always_comb begin
      if (cfg.pattern_length == '0) begin
         len_used = LEN_W'(1);
      end else if (cfg.pattern_length > LEN_W'(MAX_PATTERN)) begin
         len_used = LEN_W'(MAX_PATTERN);
      end else begin
         len_used = cfg.pattern_length;
      end
      len_m1 = len_used - LEN_W'(1);
   end

   // shift the new byte in at the top of the window
   always_comb begin
      for (int j = 0; j < MAX_PATTERN - 1; j++) begin
         win_in[j] = win_ff[j+1];
      end
      win_in[MAX_PATTERN-1] = req_data_byte;
   end

   // pattern byte k lines up with window slot MAX_PATTERN - len + k
   always_comb begin
      match = 1'b1;
      pick  = '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         pick = (LEN_W+1)'(MAX_PATTERN) - {1'b0, len_used} + (LEN_W+1)'(k);
         if ((LEN_W'(k) < len_used) && cfg.care_mask[k]) begin
            if (win_in[pick[WIN_IDX_W-1:0]] != pattern[8*k +: 8]) begin
               match = 1'b0;
            end
         end
      end
   end

   assign hit      = (count_ff >= OFFSET_BITS'(len_m1)) & match;
   assign diff     = count_ff - OFFSET_BITS'(len_m1);
   assign diff_ext = {{OFFSET_OUT_W{1'b0}}, diff};
   assign count_in = (count_ff != '1) ? count_ff + OFFSET_BITS'(1) : count_ff;

   always_comb begin
      push.valid               = fire & ~reported_ff & (hit | req_last_byte);
      push.result.found        = hit;
      push.result.match_offset = hit ? diff_ext[OFFSET_OUT_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         reported_ff <= 1'b0;
      end else if (fire) begin
         if (req_last_byte) begin
            count_ff    <= '0;
            reported_ff <= 1'b0;
         end else if (!reported_ff) begin
            count_ff    <= count_in;
            reported_ff <= hit;
         end
      end
   end

   // only bytes of the current image are ever compared, so no clear needed
   always_ff @(posedge clock) begin
      if (fire && !reported_ff) begin
         win_ff <= win_in;
      end
   end

   a_no_result_after_hit: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> !push.valid)
      else $error("result pushed after the image already reported");

   a_miss_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (push.valid && !push.result.found) |-> req_last_byte)
      else $error("not-found result before the final byte");

   a_hit_marks_image: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.result.found && !req_last_byte) |=> reported_ff)
      else $error("match did not mark the image as reported");

endmodule

[src/mbps_fifo.sv]
// Two-entry result queue between the front end and the output stage.
// Uses mbps_pkg for result_type and push_type.
module mbps_fifo import mbps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   output logic       full,
   output logic       not_empty,
   output result_type head
);

   localparam int DEPTH = 2;

   result_type slot_ff [DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_pop;

   assign full      = (count_ff == 2'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_pop    = pop & not_empty;

   always_comb begin
      count_in = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.result;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full))
      else $error("push into a full result queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("result queue count out of range");

endmodule

[src/mbps_back.sv]
// Output stage: registers the queue head onto the result channel.
// Uses mbps_pkg for result_type.
module mbps_back import mbps_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  result_type              head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_found,
   output logic [OFFSET_OUT_W-1:0] rsp_match_offset
);

   logic       valid_ff;
   result_type beat_ff;

   // load the queue head, if any, whenever the output register is empty or being drained
   assign pop              = head_valid & (~valid_ff | rsp_ready);
   assign rsp_valid        = valid_ff;
   assign rsp_found        = beat_ff.found;
   assign rsp_match_offset = beat_ff.match_offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         beat_ff <= head;
      end
   end

endmodule

[src/masked_byte_pattern_search.sv]
// Masked byte pattern search, top level: configuration, front end, result
// queue and output stage. Depends on mbps_pkg and the mbps_* modules.
//
//   channel   direction  ports                                    role
//   req       in         req_valid/ready, data_byte, last_byte   image byte beats
//   rsp       out        rsp_valid/ready, found, match_offset    one result per image
//   config    in/out     psel penable pwrite paddr pwdata prdata  registers at 8*i
//
// One byte beat per cycle; the masked compare over the window is done in the
// accepting cycle. A result reaches rsp via the queue and output register.
// req_ready falls only while the two-entry result queue is full.
// Synchronous reset clears control state; registers return to their defaults.
module masked_byte_pattern_search import mbps_pkg::*; #(
   parameter int MAX_PATTERN = 16,
   parameter int OFFSET_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_last_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_found,
   output logic [OFFSET_OUT_W-1:0] rsp_match_offset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   cfg_type    cfg;
   push_type   push;
   logic       queue_full;
   logic       queue_not_empty;
   logic       pop;
   result_type head;

   mbps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mbps_front #(
      .MAX_PATTERN (MAX_PATTERN),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .queue_full    (queue_full),
      .push          (push)
   );

   mbps_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head)
   );

   mbps_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (queue_not_empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset)
   );

endmodule
